[rtl/ps2kst_pkg.sv]
// ----------------------------------------------------------------------------
// ps2kst_pkg
// Shared types and constants for the PS/2 scan code key state tracker.
// ----------------------------------------------------------------------------
package ps2kst_pkg;

    localparam int unsigned KEY_BITS  = 8;
    localparam int unsigned KEY_COUNT = 1 << KEY_BITS;

    localparam logic [KEY_BITS-1:0] PREFIX_EXTENDED = 8'hE0;
    localparam logic [KEY_BITS-1:0] PREFIX_BREAK    = 8'hF0;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [KEY_COUNT-1:0] key_map_t;

    typedef struct packed {
        command_t command;
        key_t     rx_byte;
        key_t     query_key;
        logic     query_extended;
    } scan_item_t;

    typedef struct packed {
        logic key_down;
        logic event_valid;
        key_t event_key;
        logic event_extended;
        logic event_release;
    } key_result_t;

endpackage

[rtl/ps2kst_if.sv]
// ----------------------------------------------------------------------------
// ps2kst interfaces
// Request channel (scan bytes and queries) and result channel.
// ----------------------------------------------------------------------------
interface ps2kst_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;
    logic [7:0] query_key;
    logic       query_extended;

    modport source (output valid, command, rx_byte, query_key, query_extended,
                    input ready);
    modport sink   (input valid, command, rx_byte, query_key, query_extended,
                    output ready);
endinterface

interface ps2kst_rsp_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic       event_valid;
    logic [7:0] event_key;
    logic       event_extended;
    logic       event_release;

    modport source (output valid, key_down, event_valid, event_key, event_extended,
                    event_release, input ready);
    modport sink   (input valid, key_down, event_valid, event_key, event_extended,
                    event_release, output ready);
endinterface

[rtl/ps2kst_keymap.sv]
// ----------------------------------------------------------------------------
// ps2kst_keymap
// Prefix tracking, plain and extended key-down maps, and result decode.
// ----------------------------------------------------------------------------
module ps2kst_keymap
    import ps2kst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  scan_item_t  item,
    output key_result_t result
);

    logic     ext_pending_reg, ext_pending_next;
    logic     rel_pending_reg, rel_pending_next;
    key_map_t plain_map_reg, plain_map_next;
    key_map_t ext_map_reg, ext_map_next;

    logic is_prefix_ext;
    logic is_prefix_brk;
    logic is_key_byte;

    assign is_prefix_ext = (item.rx_byte == PREFIX_EXTENDED);
    assign is_prefix_brk = (item.rx_byte == PREFIX_BREAK);
    assign is_key_byte   = (item.command == CMD_BYTE) && !is_prefix_ext && !is_prefix_brk;

    always_comb
    begin
        result = '0;
        case (item.command)
            CMD_QUERY:
            begin
                result.key_down = item.query_extended ? ext_map_reg[item.query_key]
                                                      : plain_map_reg[item.query_key];
            end
            CMD_BYTE:
            begin
                if (is_key_byte)
                begin
                    result.event_valid    = 1'b1;
                    result.event_key      = item.rx_byte;
                    result.event_extended = ext_pending_reg;
                    result.event_release  = rel_pending_reg;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        ext_pending_next = ext_pending_reg;
        rel_pending_next = rel_pending_reg;
        plain_map_next   = plain_map_reg;
        ext_map_next     = ext_map_reg;
        if (fire && (item.command == CMD_BYTE))
        begin
            if (is_prefix_ext)
            begin
                ext_pending_next = 1'b1;
            end
            else if (is_prefix_brk)
            begin
                rel_pending_next = 1'b1;
            end
            else
            begin
                // make sets the bit, break clears it
                if (ext_pending_reg)
                begin
                    ext_map_next[item.rx_byte] = !rel_pending_reg;
                end
                else
                begin
                    plain_map_next[item.rx_byte] = !rel_pending_reg;
                end
                ext_pending_next = 1'b0;
                rel_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_pending_reg <= 1'b0;
            rel_pending_reg <= 1'b0;
            plain_map_reg   <= '0;
            ext_map_reg     <= '0;
        end
        else
        begin
            ext_pending_reg <= ext_pending_next;
            rel_pending_reg <= rel_pending_next;
            plain_map_reg   <= plain_map_next;
            ext_map_reg     <= ext_map_next;
        end
    end

`ifndef SYNTHESIS
    a_query_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.command == CMD_QUERY) |=>
            $stable(plain_map_reg) && $stable(ext_map_reg)
            && $stable(ext_pending_reg) && $stable(rel_pending_reg))
        else $error("query changed key state");

    a_ext_prefix_arms: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (item.command == CMD_BYTE) && is_prefix_ext |=> ext_pending_reg)
        else $error("E0 prefix not armed");

    a_event_drops_prefixes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_key_byte |=> !ext_pending_reg && !rel_pending_reg)
        else $error("prefixes not dropped after key byte");

    a_plain_make_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_key_byte && !ext_pending_reg && !rel_pending_reg |=>
            plain_map_reg[$past(item.rx_byte)] && $stable(ext_map_reg))
        else $error("plain make did not set key bit");
`endif

endmodule

[rtl/ps2_scan_code_key_state_tracker.sv]
// ----------------------------------------------------------------------------
// ps2_scan_code_key_state_tracker
// Tracks PS/2 set 2 make/break codes in plain and E0 key-down maps.
// ----------------------------------------------------------------------------
// a request is registered in item_reg, then its result in result_reg once that slot is free
// throughput: one request per cycle while results are taken, set by the single map update per item
// the result register lets a new request in while a result waits to be taken
// reset clears both key maps and both prefixes at once, no clearing pass
module ps2_scan_code_key_state_tracker
    import ps2kst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ps2kst_req_if.sink   scan,
    ps2kst_rsp_if.source result
);

    scan_item_t  item_reg, item_next;
    logic        item_valid_reg, item_valid_next;
    key_result_t result_reg, result_next;
    logic        result_valid_reg, result_valid_next;

    logic accept;
    logic advance;

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign scan.ready = !item_valid_reg || advance;
    assign accept     = scan.valid && scan.ready;

    assign item_next.command        = command_t'(scan.command);
    assign item_next.rx_byte        = scan.rx_byte;
    assign item_next.query_key      = scan.query_key;
    assign item_next.query_extended = scan.query_extended;

    assign item_valid_next   = accept || (item_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result.ready);

    ps2kst_keymap u_keymap (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid          = result_valid_reg;
    assign result.key_down       = result_reg.key_down;
    assign result.event_valid    = result_reg.event_valid;
    assign result.event_key      = result_reg.event_key;
    assign result.event_extended = result_reg.event_extended;
    assign result.event_release  = result_reg.event_release;

endmodule

[dv/tb_ps2_scan_code_key_state_tracker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_scan_code_key_state_tracker
// Drives scan code bytes and key queries into the tracker with random gaps
// and stalls. It keeps its own copy of both key-down maps and the pending
// E0/F0 prefixes, and checks every result against it field by field.
// ----------------------------------------------------------------------------
module tb_ps2_scan_code_key_state_tracker;
    import ps2kst_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int OUTPUT_HOLD    = 300;
    localparam int DRAIN_TAIL     = 4;
    localparam int REPORT_LIMIT   = 40;

    logic clk = 1'b0;
    logic rst_n;

    ps2kst_req_if scan_bus();
    ps2kst_rsp_if result_bus();

    ps2_scan_code_key_state_tracker DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_bus),
        .result (result_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // tracker state mirrored on the testbench side
    logic [KEY_COUNT-1:0] plain_keys_down;
    logic [KEY_COUNT-1:0] e0_keys_down;
    logic                 e0_armed;
    logic                 break_armed;

    key_result_t key_results_due[$];

    int  requests_sent;
    int  mismatch_count;
    int  make_count;
    int  break_count;
    int  query_hits;
    bit  source_gaps;
    bit  sink_stalls;
    int  sink_hold_left;
    int  quiet_cycles;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic key_t pick_key();
        if ($urandom_range(0, 9) < 7)
            return key_t'(8'h10 + $urandom_range(0, 15));
        return key_t'($urandom_range(0, 255));
    endfunction

    function automatic key_result_t track_scan_request(scan_item_t req);
        key_result_t res;
        res = '0;
        if (req.command == CMD_QUERY)
        begin
            res.key_down = req.query_extended ? e0_keys_down[req.query_key]
                                              : plain_keys_down[req.query_key];
            if (res.key_down)
                query_hits++;
        end
        else if (req.rx_byte == PREFIX_EXTENDED)
            e0_armed = 1'b1;
        else if (req.rx_byte == PREFIX_BREAK)
            break_armed = 1'b1;
        else
        begin
            if (e0_armed)
                e0_keys_down[req.rx_byte] = !break_armed;
            else
                plain_keys_down[req.rx_byte] = !break_armed;
            res.event_valid    = 1'b1;
            res.event_key      = req.rx_byte;
            res.event_extended = e0_armed;
            res.event_release  = break_armed;
            if (break_armed)
                break_count++;
            else
                make_count++;
            e0_armed    = 1'b0;
            break_armed = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    endtask

    task automatic offer_request(command_t cmd, key_t rx, key_t qkey, logic qext);
        scan_item_t req;
        int         gap;
        gap = source_gaps ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            scan_bus.valid <= 1'b0;
        end
        @(negedge clk);
        scan_bus.valid          <= 1'b1;
        scan_bus.command        <= cmd;
        scan_bus.rx_byte        <= rx;
        scan_bus.query_key      <= qkey;
        scan_bus.query_extended <= qext;
        do
            @(posedge clk);
        while (!scan_bus.ready);
        req.command        = cmd;
        req.rx_byte        = rx;
        req.query_key      = qkey;
        req.query_extended = qext;
        key_results_due.push_back(track_scan_request(req));
        requests_sent++;
    endtask

    task automatic send_byte(key_t b);
        offer_request(CMD_BYTE, b, key_t'($urandom), 1'($urandom));
    endtask

    task automatic send_query(key_t k, logic ext);
        offer_request(CMD_QUERY, key_t'($urandom), k, ext);
    endtask

    // prefixes in either order, now and then each of them repeated
    task automatic send_key_event(key_t k, bit extended, bit is_break);
        bit e0_first;
        int copies;
        e0_first = 1'($urandom_range(0, 1));
        copies   = ($urandom_range(0, 7) == 0) ? 2 : 1;
        if (extended && e0_first)
            repeat (copies) send_byte(PREFIX_EXTENDED);
        if (is_break)
            repeat (copies) send_byte(PREFIX_BREAK);
        if (extended && !e0_first)
            repeat (copies) send_byte(PREFIX_EXTENDED);
        send_byte(k);
    endtask

    task automatic run_mixed_traffic(int count);
        int target;
        int r;
        target = requests_sent + count;
        while (requests_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_key_event(pick_key(), 1'($urandom_range(0, 1)),
                               $urandom_range(0, 2) == 0);
            else if (r < 85)
                send_query($urandom_range(0, 1) ? pick_key() : key_t'($urandom),
                           1'($urandom));
            else
                // stray bytes, including dangling prefixes
                send_byte(key_t'($urandom));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        scan_bus.valid <= 1'b0;
        while (key_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_query(8'h00, 1'b0);
        send_query(8'hFF, 1'b0);
        send_query(8'hFF, 1'b1);
        send_byte(PREFIX_EXTENDED);
        send_byte(8'hFF);
        send_query(8'hFF, 1'b1);
        send_byte(PREFIX_BREAK);
        send_byte(8'h00);
        send_query(8'h00, 1'b0);
        send_byte(PREFIX_EXTENDED);
        send_byte(PREFIX_BREAK);
        send_byte(8'hFF);
        // break prefix ahead of the extended prefix
        send_byte(PREFIX_BREAK);
        send_byte(PREFIX_EXTENDED);
        send_byte(8'h12);
        // a repeated prefix stays armed
        send_byte(PREFIX_EXTENDED);
        send_byte(PREFIX_EXTENDED);
        send_byte(8'h5A);
        send_byte(PREFIX_BREAK);
        send_byte(PREFIX_BREAK);
        send_byte(8'h5A);
        send_query(8'h5A, 1'b1);
        send_query(PREFIX_EXTENDED, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_mixed_traffic(1100);
        wait_drained();
    endtask

    task automatic test_output_stall();
        sink_hold_left = OUTPUT_HOLD;
        source_gaps    = 1'b0;
        run_mixed_traffic(80);
        source_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic test_drain_pause();
        run_mixed_traffic(200);
        wait_drained();
        run_mixed_traffic(200);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        run_mixed_traffic(150);
        wait_drained();
        source_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // result side: random stalls plus an occasional long hold-off
    initial
    begin
        int stall_left;
        stall_left       = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                result_bus.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                result_bus.ready <= (stall_left == 0);
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        key_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (key_results_due.size() == 0)
                report_mismatch("result with no request due", 1, 0);
            else
            begin
                want = key_results_due.pop_front();
                if (result_bus.key_down !== want.key_down)
                    report_mismatch("key_down", result_bus.key_down, want.key_down);
                if (result_bus.event_valid !== want.event_valid)
                    report_mismatch("event_valid", result_bus.event_valid, want.event_valid);
                if (result_bus.event_key !== want.event_key)
                    report_mismatch("event_key", result_bus.event_key, want.event_key);
                if (result_bus.event_extended !== want.event_extended)
                    report_mismatch("event_extended", result_bus.event_extended,
                                    want.event_extended);
                if (result_bus.event_release !== want.event_release)
                    report_mismatch("event_release", result_bus.event_release,
                                    want.event_release);
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (scan_bus.valid && scan_bus.ready)
                       || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("no handshake for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, key_results_due.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        scan_bus.valid          = 1'b0;
        scan_bus.command        = CMD_BYTE;
        scan_bus.rx_byte        = '0;
        scan_bus.query_key      = '0;
        scan_bus.query_extended = 1'b0;
        plain_keys_down         = '0;
        e0_keys_down            = '0;
        e0_armed                = 1'b0;
        break_armed             = 1'b0;
        requests_sent           = 0;
        mismatch_count          = 0;
        make_count              = 0;
        break_count             = 0;
        query_hits              = 0;
        source_gaps             = 1'b1;
        sink_stalls             = 1'b1;
        sink_hold_left          = 0;
        rst_n                   = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_stall();
        test_drain_pause();
        test_back_to_back();

        $display("ran %0d requests: %0d presses, %0d releases, %0d queries hit a held key",
                 requests_sent, make_count, break_count, query_hits);
        $display("covered both prefix orders, repeated prefixes, stray bytes and stalls");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
